/* design/bbfc_pkg.sv */
// Shared types, constants and state codes for the byte-budget FIFO cache.
package bbfc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 64;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned SIZE_W = 20;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned EVICT_W = 7;
  localparam logic [SIZE_W-1:0] RESET_CAPACITY = 20'd1024;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic operation;
    logic [KEY_W-1:0] key;
    logic [SIZE_W-1:0] item_size;
    logic [SIZE_W-1:0] item_length;
    logic [HANDLE_W-1:0] item_handle;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic [SIZE_W-1:0] found_size;
    logic [SIZE_W-1:0] found_length;
    logic [HANDLE_W-1:0] found_handle;
    logic [EVICT_W-1:0] evicted_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] length;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_RELEASE,
    ST_EVICT_RD,
    ST_EVICT,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

/* design/bbfc_slot_ram.sv */
// Slot memory: one write port, one registered read port.
module bbfc_slot_ram #(
  parameter int unsigned ENTRIES = bbfc_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(ENTRIES)-1:0]    waddr,
  input  bbfc_pkg::slot_t               wdata,
  input  logic [$clog2(ENTRIES)-1:0]    raddr,
  output bbfc_pkg::slot_t               rdata
);
  import bbfc_pkg::*;

  slot_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/byte_budget_fifo_cache.sv */
// Top level: byte-budget FIFO cache with sequencer and slot memory.
// Sequence: a fetch scans the ring slot by slot, reading each slot and then comparing
//   its registered key, and returns its result in ST_DONE. An insert scans the same
//   way, releases the old size of a replaced entry, evicts oldest entries until the item
//   fits, then writes; an insert larger than the capacity ends with no write. One transaction at a time.
// The scan is bounded by the single slot memory read port: each slot is issued,
//   then its registered data is compared.
// Reset (rst, synchronous): ring empty, bytes used zero, capacity 1024.
//   Slot contents are not cleared; only data from slots inside the ring is ever used.
module byte_budget_fifo_cache #(
  parameter int unsigned ENTRIES = bbfc_pkg::ENTRIES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bbfc_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bbfc_pkg::out_item_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bbfc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_t state, state_next;
  in_item_t req;
  logic [SIZE_W-1:0] capacity;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [SIZE_W-1:0] used;
  logic [CW-1:0] scan;      // offset being searched
  logic present;
  logic [CW-1:0] pos;
  logic [EVICT_W-1:0] evicted;
  out_item_t result;
  logic release_pending;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  slot_t ram_wdata, ram_rdata;

  bbfc_slot_ram #(.ENTRIES(ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Ring index arithmetic; ENTRIES may not be a power of two.
  function automatic logic [IW-1:0] ring_idx(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW+1)'(ENTRIES)) begin
      s = s - (CW+1)'(ENTRIES);
    end
    return s[IW-1:0];
  endfunction

  assign pready = 1'b1;
  assign prdata = {{(32-SIZE_W){1'b0}}, capacity};
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign out_data = result;

  logic [SIZE_W:0] fit_sum;
  logic over;
  assign fit_sum = {1'b0, used} + {1'b0, req.item_size};
  assign over = (fit_sum > {1'b0, capacity}) || (!present && count >= FULL);

  // Read address follows state: scan slot, present slot, then oldest slot.
  always_comb begin
    ram_raddr = head;
    if (state == ST_SEARCH) begin
      ram_raddr = ring_idx(head, scan);
    end else if (state == ST_RELEASE) begin
      ram_raddr = ring_idx(head, pos);
    end
  end

  always_comb begin
    ram_we = (state == ST_WRITE);
    ram_waddr = present ? ring_idx(head, pos) : ring_idx(head, count);
    ram_wdata = '{key: req.key, size: req.item_size, length: req.item_length,
                  handle: req.item_handle};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SEARCH;
      ST_SEARCH: begin
        // Scan until a match or the ring's end; then finish, or go on to release or evict.
        priority if (scan < count) begin
          state_next = ST_SEARCH_WAIT;
        end else if (req.operation == OP_FETCH || req.item_size > capacity) begin
          state_next = ST_DONE;
        end else begin
          state_next = present ? ST_RELEASE : ST_EVICT_RD;
        end
      end
      ST_SEARCH_WAIT: state_next = ST_SEARCH;
      ST_RELEASE: state_next = ST_EVICT_RD;
      ST_EVICT_RD: state_next = ST_EVICT;
      ST_EVICT: state_next = (count != '0 && over) ? ST_EVICT_RD : ST_WRITE;
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= RESET_CAPACITY;
      head <= '0;
      count <= '0;
      used <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
        capacity <= pwdata[SIZE_W-1:0];
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            scan <= '0;
            present <= 1'b0;
            pos <= '0;
            evicted <= '0;
            result <= '0;
          end
        end
        ST_SEARCH_WAIT: begin
          if (ram_rdata.key == req.key) begin
            present <= 1'b1;
            pos <= scan;
            scan <= count;
            if (req.operation == OP_FETCH) begin
              result.hit <= 1'b1;
              result.found_size <= ram_rdata.size;
              result.found_length <= ram_rdata.length;
              result.found_handle <= ram_rdata.handle;
            end
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_EVICT_RD: begin
          // Drop the replaced entry's old size once its slot data arrives.
          if (release_pending) begin
            used <= (ram_rdata.size > used) ? '0 : used - ram_rdata.size;
          end
        end
        ST_EVICT: begin
          if (count != '0 && over) begin
            if (present && pos == '0) begin
              present <= 1'b0;
            end else begin
              used <= (ram_rdata.size > used) ? '0 : used - ram_rdata.size;
              evicted <= evicted + 1'b1;
              if (present) pos <= pos - 1'b1;
            end
            head <= ring_idx(head, CW'(1));
            count <= count - 1'b1;
          end
        end
        ST_WRITE: begin
          if (!present) count <= count + 1'b1;
          used <= used + req.item_size;
          result.hit <= 1'b1;
          result.evicted_count <= evicted;
        end
        default: ;
      endcase
    end
  end

  // Mark the cycle in which the present slot's data is on the read port.
  always_ff @(posedge clk) begin
    if (rst) begin
      release_pending <= 1'b0;
    end else begin
      release_pending <= (state == ST_RELEASE);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("ring count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_SEARCH)
    else $error("accepted transaction did not start search");
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (present || count < FULL))
    else $error("append into full ring");

endmodule
